/* sv/ts_audio_pid_payload_extractor_macros.svh */
// Assertion macros for the transport stream audio PID payload extractor.
// Included by the top level; no other dependencies.
`ifndef TS_AUDIO_PID_PAYLOAD_EXTRACTOR_MACROS_SVH
`define TS_AUDIO_PID_PAYLOAD_EXTRACTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define TS_APE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ts_ape assertion failed");

// next-cycle implication, disabled during reset
`define TS_APE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ts_ape assertion failed");

`endif

/* sv/ts_ape_pkg.sv */
// Shared types and constants for the transport stream audio PID payload extractor.
// No dependencies.
package ts_ape_pkg;

   localparam int TS_PACKET_BYTES_DEFAULT = 188;
   localparam int TS_HEADER_BYTES         = 4;
   localparam int TS_PAYLOAD_BYTES        = 184;
   localparam int TS_PAYLOAD_END          = TS_HEADER_BYTES + TS_PAYLOAD_BYTES;

   localparam int BYTE_W    = 8;
   localparam int PID_W     = 13;
   localparam int SAMPLE_W  = 16;
   localparam int SKIP_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_PID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RTP_HEADER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PES_SKIP    = 2'd2;

   localparam logic [PID_W-1:0]  TARGET_PID_RESET = 13'h1100;
   localparam logic [BYTE_W-1:0] RTP_HEADER_RESET = 8'd12;
   localparam logic [BYTE_W-1:0] PES_SKIP_RESET   = 8'd20;

   // header byte 1 bit 6 is the unit start flag; header byte 3 bit 5 flags an adaptation field
   localparam int PUSI_BIT  = 6;
   localparam int ADAPT_BIT = 5;

   // queue between parser and sample packer
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } payload_byte_type;

endpackage

/* sv/ts_ape_if.sv */
// Channel interfaces: byte requests, sample responses and register writes.
// Depends on ts_ape_pkg.
interface ts_ape_req_if;
   logic                            valid;
   logic                            ready;
   logic [ts_ape_pkg::BYTE_W-1:0]   data_byte;
   logic                            datagram_start;
   modport source (output valid, output data_byte, output datagram_start, input ready);
   modport sink   (input valid, input data_byte, input datagram_start, output ready);
endinterface

interface ts_ape_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ts_ape_pkg::SAMPLE_W-1:0] audio_sample;
   modport source (output valid, output audio_sample, input ready);
   modport sink   (input valid, input audio_sample, output ready);
endinterface

interface ts_ape_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ts_ape_pkg::CSR_IDX_W-1:0] index;
   logic [ts_ape_pkg::CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/ts_audio_pid_payload_extractor.sv */
// Top level of the transport stream audio PID payload extractor.
// Depends on ts_ape_pkg, ts_ape_if, ts_ape_front, ts_ape_queue, ts_ape_back and the macros header.
//
// Takes one RTP datagram byte per clock cycle, drops the RTP header, cuts the rest into
// transport packets and emits the payload of packets on the target PID as 16-bit big-endian
// samples, one sample for every second kept byte. A byte is accepted every cycle as long as
// the two-entry queue between the header parser and the sample packer has room; the packer
// drains one byte per cycle, taking a second byte only while its registered output is free;
// a sample's second byte passes the queue, then that register. Registers may be written at
// any time the block is idle and take effect on the next byte; there is no clearing pass.
`include "ts_audio_pid_payload_extractor_macros.svh"

module ts_audio_pid_payload_extractor #(
   parameter int TS_PACKET_BYTES = ts_ape_pkg::TS_PACKET_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ts_ape_req_if.sink    req_chan,
   ts_ape_rsp_if.source  rsp_chan,
   ts_ape_csr_if.sink    csr_chan
);

   ts_ape_pkg::payload_byte_type       q_push;
   ts_ape_pkg::payload_byte_type       q_head;
   logic                               q_pop;
   logic                               q_full;
   logic [ts_ape_pkg::QUEUE_CNT_W-1:0] q_count;

   ts_ape_front #(
      .TS_PACKET_BYTES(TS_PACKET_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (q_full),
      .push       (q_push)
   );

   ts_ape_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .head  (q_head),
      .full  (q_full),
      .count (q_count)
   );

   ts_ape_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

   `TS_APE_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, q_count <= ts_ape_pkg::QUEUE_CNT_W'(ts_ape_pkg::QUEUE_DEPTH))
   `TS_APE_ASSERT_IMP(a_push_on_accept, clock, reset, q_push.valid, req_chan.valid && req_chan.ready)
   `TS_APE_ASSERT_IMP(a_sample_from_pop, clock, reset, rsp_chan.valid && !$past(rsp_chan.valid), $past(q_pop))

endmodule

/* sv/ts_ape_front.sv */
// Front end: register file, RTP header drop and transport packet header parse.
// Pushes each kept payload byte toward the queue. Depends on ts_ape_pkg, ts_ape_if.
module ts_ape_front #(
   parameter int TS_PACKET_BYTES = ts_ape_pkg::TS_PACKET_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   ts_ape_req_if.sink                    req_chan,
   ts_ape_csr_if.sink                    csr_chan,
   input  logic                          queue_full,
   output ts_ape_pkg::payload_byte_type  push
);

   localparam int PosW = $clog2(TS_PACKET_BYTES);

   logic [ts_ape_pkg::PID_W-1:0]  target_pid_ff;
   logic [ts_ape_pkg::BYTE_W-1:0] rtp_hdr_ff;
   logic [ts_ape_pkg::BYTE_W-1:0] pes_skip_ff;

   logic [ts_ape_pkg::BYTE_W-1:0] skip_cnt_ff, skip_cnt_in;
   logic [PosW-1:0]               pos_ff, pos_in;
   logic [ts_ape_pkg::BYTE_W-1:0] hdr_hi_ff, hdr_hi_in;
   logic [ts_ape_pkg::BYTE_W-1:0] hdr_lo_ff, hdr_lo_in;
   logic [ts_ape_pkg::SKIP_W-1:0] skip_left_ff, skip_left_in;
   logic                          pid_match_ff, pid_match_in;

   logic                          accept;
   logic [ts_ape_pkg::BYTE_W-1:0] skip_eff;
   logic [PosW-1:0]               pos_eff;
   logic [ts_ape_pkg::BYTE_W-1:0] unit_skip;
   logic [ts_ape_pkg::BYTE_W-1:0] b;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_pid_ff <= ts_ape_pkg::TARGET_PID_RESET;
         rtp_hdr_ff    <= ts_ape_pkg::RTP_HEADER_RESET;
         pes_skip_ff   <= ts_ape_pkg::PES_SKIP_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            ts_ape_pkg::CSR_TARGET_PID: target_pid_ff <= csr_chan.data;
            ts_ape_pkg::CSR_RTP_HEADER: rtp_hdr_ff <= csr_chan.data[ts_ape_pkg::BYTE_W-1:0];
            ts_ape_pkg::CSR_PES_SKIP:   pes_skip_ff <= csr_chan.data[ts_ape_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_cnt_ff  <= '0;
         pos_ff       <= '0;
         hdr_hi_ff    <= '0;
         hdr_lo_ff    <= '0;
         skip_left_ff <= '0;
         pid_match_ff <= 1'b0;
      end else begin
         skip_cnt_ff  <= skip_cnt_in;
         pos_ff       <= pos_in;
         hdr_hi_ff    <= hdr_hi_in;
         hdr_lo_ff    <= hdr_lo_in;
         skip_left_ff <= skip_left_in;
         pid_match_ff <= pid_match_in;
      end
   end

   always_comb begin
      skip_eff     = req_chan.datagram_start ? rtp_hdr_ff : skip_cnt_ff;
      pos_eff      = req_chan.datagram_start ? '0 : pos_ff;
      unit_skip    = hdr_hi_ff[ts_ape_pkg::PUSI_BIT] ? pes_skip_ff : '0;
      skip_cnt_in  = skip_cnt_ff;
      pos_in       = pos_ff;
      hdr_hi_in    = hdr_hi_ff;
      hdr_lo_in    = hdr_lo_ff;
      skip_left_in = skip_left_ff;
      pid_match_in = pid_match_ff;
      push.valid   = 1'b0;
      push.data    = b;
      if (accept) begin
         if (skip_eff != '0) begin
            // drop an RTP header byte
            skip_cnt_in = skip_eff - 8'd1;
            pos_in      = pos_eff;
         end else begin
            skip_cnt_in = '0;
            priority if (pos_eff == PosW'(0)) begin
               pid_match_in = 1'b0;
            end else if (pos_eff == PosW'(1)) begin
               hdr_hi_in = b;
            end else if (pos_eff == PosW'(2)) begin
               hdr_lo_in    = b;
               pid_match_in = ({hdr_hi_ff[4:0], b} == target_pid_ff);
            end else if (pos_eff == PosW'(3)) begin
               hdr_lo_in    = b;
               skip_left_in = {1'b0, unit_skip};
            end else if (pos_eff < PosW'(ts_ape_pkg::TS_PAYLOAD_END)) begin
               if (pos_eff == PosW'(ts_ape_pkg::TS_HEADER_BYTES) &&
                   hdr_lo_ff[ts_ape_pkg::ADAPT_BIT]) begin
                  // adaptation length byte: skip its value plus the PES header
                  skip_left_in = {1'b0, b} + {1'b0, unit_skip};
               end else if (pid_match_ff) begin
                  if (skip_left_ff != '0) begin
                     skip_left_in = skip_left_ff - 9'd1;
                  end else begin
                     push.valid = 1'b1;
                  end
               end
            end else begin
               // trailing bytes of a long packet: ignore
            end
            pos_in = (pos_eff == PosW'(TS_PACKET_BYTES - 1)) ? '0 : pos_eff + PosW'(1);
         end
      end
   end

endmodule

/* sv/ts_ape_queue.sv */
// Short byte queue decoupling the parser from the sample packer.
// Depends on ts_ape_pkg.
module ts_ape_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ts_ape_pkg::payload_byte_type            push,
   input  logic                                    pop,
   output ts_ape_pkg::payload_byte_type            head,
   output logic                                    full,
   output logic [ts_ape_pkg::QUEUE_CNT_W-1:0]      count
);

   logic [ts_ape_pkg::BYTE_W-1:0]      entry_ff [ts_ape_pkg::QUEUE_DEPTH];
   logic [ts_ape_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ts_ape_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ts_ape_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                               do_pop;

   localparam logic [ts_ape_pkg::QUEUE_PTR_W-1:0] LastPtr =
      ts_ape_pkg::QUEUE_PTR_W'(ts_ape_pkg::QUEUE_DEPTH - 1);

   assign full       = (count_ff == ts_ape_pkg::QUEUE_CNT_W'(ts_ape_pkg::QUEUE_DEPTH));
   assign count      = count_ff;
   assign head.valid = (count_ff != '0);
   assign head.data  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

/* sv/ts_ape_back.sv */
// Back end: pairs payload bytes big-endian into 16-bit samples behind an output register.
// Depends on ts_ape_pkg, ts_ape_if.
module ts_ape_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ts_ape_pkg::payload_byte_type  head,
   output logic                          pop,
   ts_ape_rsp_if.source                  rsp_chan
);

   logic                            held_ff, held_in;
   logic [ts_ape_pkg::BYTE_W-1:0]   held_byte_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [ts_ape_pkg::SAMPLE_W-1:0] out_sample_ff;
   logic                            out_free;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.audio_sample = out_sample_ff;
   assign out_free              = !out_valid_ff || rsp_chan.ready;
   // a first byte can always be held; a second one needs room in the output register
   assign pop                   = head.valid && (!held_ff || out_free);

   always_comb begin
      held_in      = held_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (pop) begin
         held_in = !held_ff;
         if (held_ff) begin
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !held_ff) begin
         held_byte_ff <= head.data;
      end
      if (pop && held_ff) begin
         out_sample_ff <= {held_byte_ff, head.data};
      end
   end

endmodule

/* tb/sv/tb_ts_audio_pid_payload_extractor.sv */
`timescale 1ns / 100ps
// Testbench for the transport stream audio PID payload extractor: RTP datagrams built from
// random transport packets go in, every 16-bit sample out is checked against a predictor.
// Depends on ts_ape_pkg, the ts_ape channel interfaces and the extractor RTL.

class pid_payload_tracker;
   logic [ts_ape_pkg::PID_W-1:0]    target_pid;
   logic [ts_ape_pkg::BYTE_W-1:0]   rtp_header_bytes;
   logic [ts_ape_pkg::BYTE_W-1:0]   pes_header_skip;
   int unsigned                     packet_bytes;
   logic [ts_ape_pkg::BYTE_W-1:0]   rtp_left;
   logic [ts_ape_pkg::BYTE_W-1:0]   pkt_pos;
   logic [15:0]                     hdr;
   logic [ts_ape_pkg::SKIP_W-1:0]   skip_left;
   bit                              pid_hit;
   logic [ts_ape_pkg::BYTE_W-1:0]   held_byte;
   bit                              have_held;
   logic [ts_ape_pkg::SAMPLE_W-1:0] pending_samples[$];
   int                              mismatch_count;

   function new(int unsigned pkt_len);
      packet_bytes     = pkt_len;
      target_pid       = ts_ape_pkg::TARGET_PID_RESET;
      rtp_header_bytes = ts_ape_pkg::RTP_HEADER_RESET;
      pes_header_skip  = ts_ape_pkg::PES_SKIP_RESET;
      rtp_left         = '0;
      pkt_pos          = '0;
      hdr              = '0;
      skip_left        = '0;
      pid_hit          = 1'b0;
      held_byte        = '0;
      have_held        = 1'b0;
      mismatch_count   = 0;
   endfunction

   function void write_reg(logic [ts_ape_pkg::CSR_IDX_W-1:0] idx,
                           logic [ts_ape_pkg::CSR_DAT_W-1:0] val);
      case (idx)
         ts_ape_pkg::CSR_TARGET_PID: target_pid       = val[ts_ape_pkg::PID_W-1:0];
         ts_ape_pkg::CSR_RTP_HEADER: rtp_header_bytes = val[ts_ape_pkg::BYTE_W-1:0];
         ts_ape_pkg::CSR_PES_SKIP:   pes_header_skip  = val[ts_ape_pkg::BYTE_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the parser by one accepted request and queue any sample it completes.
   function void note_byte(logic [ts_ape_pkg::BYTE_W-1:0] b, logic start);
      logic [ts_ape_pkg::BYTE_W-1:0] pos;
      logic [ts_ape_pkg::SKIP_W-1:0] pes_part;
      if (start) begin
         rtp_left = rtp_header_bytes;
         pkt_pos  = '0;
      end
      if (rtp_left != 0) begin
         rtp_left = rtp_left - 8'd1;
         return;
      end
      pos      = pkt_pos;
      pes_part = hdr[8 + ts_ape_pkg::PUSI_BIT] ?
                 ts_ape_pkg::SKIP_W'(pes_header_skip) : '0;
      if (pos == 0) begin
         pid_hit = 1'b0;
      end else if (pos == 1) begin
         hdr[15:8] = b;
      end else if (pos == 2) begin
         hdr[7:0] = b;
         pid_hit  = ({hdr[12:8], b} == target_pid);
      end else if (pos == 3) begin
         hdr[7:0]  = b;
         skip_left = hdr[8 + ts_ape_pkg::PUSI_BIT] ?
                     ts_ape_pkg::SKIP_W'(pes_header_skip) : '0;
      end else if (pos < ts_ape_pkg::TS_PAYLOAD_END) begin
         if (pos == ts_ape_pkg::TS_HEADER_BYTES && hdr[ts_ape_pkg::ADAPT_BIT]) begin
            // length byte plus its value, then the PES header
            skip_left = ts_ape_pkg::SKIP_W'(b) + pes_part;
         end else if (pid_hit) begin
            if (skip_left != 0) begin
               skip_left = skip_left - 1'b1;
            end else if (have_held) begin
               pending_samples.push_back({held_byte, b});
               have_held = 1'b0;
            end else begin
               held_byte = b;
               have_held = 1'b1;
            end
         end
      end
      if (int'(pos) + 1 >= packet_bytes) pkt_pos = '0;
      else pkt_pos = pos + 8'd1;
   endfunction

   function void check_sample(logic [ts_ape_pkg::SAMPLE_W-1:0] got);
      logic [ts_ape_pkg::SAMPLE_W-1:0] want;
      if (pending_samples.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: audio_sample %04h arrived with none expected", got);
         return;
      end
      want = pending_samples.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: audio_sample expected %04h, got %04h", want, got);
      end
   endfunction
endclass

module tb_ts_audio_pid_payload_extractor;
   localparam int CLK_HALF         = 6;
   localparam int PKT_BYTES        = ts_ape_pkg::TS_PACKET_BYTES_DEFAULT;
   localparam int LIMIT_CYCLES     = 400000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_BYTES      = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ts_ape_req_if req_chan ();
   ts_ape_rsp_if rsp_chan ();
   ts_ape_csr_if csr_chan ();

   pid_payload_tracker            tracker;
   logic [ts_ape_pkg::BYTE_W-1:0] dgram[$];
   int unsigned                   sent_bytes = 0;
   int unsigned                   cycle_count = 0;
   bit                            gaps_on = 1'b1;
   bit                            quiet_tail = 1'b0;
   bit                            long_hold_go = 1'b0;

   ts_audio_pid_payload_extractor #(.TS_PACKET_BYTES(PKT_BYTES)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #(CLK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            tracker.note_byte(req_chan.data_byte, req_chan.datagram_start);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            tracker.check_sample(rsp_chan.audio_sample);
      end
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin : rsp_side
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (gaps_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [ts_ape_pkg::BYTE_W-1:0] b, input logic start);
      if (gaps_on && !quiet_tail && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.data_byte      <= b;
      req_chan.datagram_start <= start;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sent_bytes++;
   endtask

   task automatic send_dgram();
      for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == 0);
   endtask

   // Append one transport packet, cut after keep_len bytes.
   function automatic void add_packet(bit force_match, int unsigned keep_len);
      logic [ts_ape_pkg::PID_W-1:0]  pid;
      bit                            pusi;
      logic [ts_ape_pkg::BYTE_W-1:0] hdr3;
      logic [ts_ape_pkg::BYTE_W-1:0] b;
      pid = ($urandom_range(0, 3) != 0) ? tracker.target_pid :
            ts_ape_pkg::PID_W'($urandom);
      if ($urandom_range(0, 7) == 0)
         pid = tracker.target_pid ^
               (ts_ape_pkg::PID_W'(1) << $urandom_range(0, ts_ape_pkg::PID_W - 1));
      pusi = ($urandom_range(0, 2) == 0);
      hdr3 = ts_ape_pkg::BYTE_W'($urandom);
      if (force_match) begin
         pid                        = tracker.target_pid;
         pusi                       = 1'b0;
         hdr3[ts_ape_pkg::ADAPT_BIT] = 1'b0;
      end
      for (int unsigned k = 0; k < keep_len; k++) begin
         if (k == 0) begin
            b = ($urandom_range(0, 9) == 0) ? ts_ape_pkg::BYTE_W'($urandom) : 8'h47;
         end else if (k == 1) begin
            b = {1'($urandom), pusi, 1'($urandom), pid[12:8]};
         end else if (k == 2) begin
            b = pid[7:0];
         end else if (k == 3) begin
            b = hdr3;
         end else if (k == ts_ape_pkg::TS_HEADER_BYTES && hdr3[ts_ape_pkg::ADAPT_BIT]) begin
            case ($urandom_range(0, 9))
               0, 1:    b = ts_ape_pkg::BYTE_W'($urandom_range(100, 183));
               2:       b = ts_ape_pkg::BYTE_W'($urandom);
               default: b = ts_ape_pkg::BYTE_W'($urandom_range(0, 30));
            endcase
         end else begin
            case ($urandom_range(0, 15))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = ts_ape_pkg::BYTE_W'($urandom);
            endcase
         end
         dgram.push_back(b);
      end
   endfunction

   task automatic send_datagram(input bit force_match, input int unsigned max_pk);
      int unsigned n;
      dgram.delete();
      repeat (tracker.rtp_header_bytes) dgram.push_back(ts_ape_pkg::BYTE_W'($urandom));
      if (!force_match && $urandom_range(0, 9) == 0) begin
         // broken datagram: noise only
         repeat ($urandom_range(1, 40)) dgram.push_back(ts_ape_pkg::BYTE_W'($urandom));
      end else begin
         n = $urandom_range(1, max_pk);
         for (int unsigned i = 0; i < n; i++) begin
            if (i == n - 1 && !force_match && $urandom_range(0, 6) == 0)
               add_packet(1'b0, $urandom_range(1, PKT_BYTES - 1));
            else
               add_packet(force_match, PKT_BYTES);
         end
      end
      send_dgram();
   endtask

   task automatic run_phase(input int unsigned budget, input int unsigned max_pk);
      int unsigned first;
      first = sent_bytes;
      while (sent_bytes - first < budget) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         send_datagram(1'b0, max_pk);
      end
   endtask

   // Hold requests until every expected sample is out, then wait out the settle time.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int unsigned pid, input int unsigned rtp,
                            input int unsigned pes);
      logic [ts_ape_pkg::CSR_IDX_W-1:0] idx[3];
      int unsigned                      val[3];
      idx[0] = ts_ape_pkg::CSR_TARGET_PID;  val[0] = pid;
      idx[1] = ts_ape_pkg::CSR_RTP_HEADER;  val[1] = rtp;
      idx[2] = ts_ape_pkg::CSR_PES_SKIP;    val[2] = pes;
      for (int i = 0; i < 3; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx[i];
         csr_chan.data  <= ts_ape_pkg::CSR_DAT_W'(val[i]);
         @(posedge clock);
         while (csr_chan.ready !== 1'b1) @(posedge clock);
         tracker.write_reg(idx[i], ts_ape_pkg::CSR_DAT_W'(val[i]));
      end
      csr_chan.valid <= 1'b0;
   endtask

   initial begin : stimulus
      tracker                 = new(PKT_BYTES);
      req_chan.valid          = 1'b0;
      req_chan.data_byte      = '0;
      req_chan.datagram_start = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.index          = ts_ape_pkg::CSR_TARGET_PID;
      csr_chan.data           = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Bytes before any datagram start parse as a packet on the reset PID; extreme
      // samples, then leave one byte held and cut the packet with a new datagram.
      dgram = '{8'h47, 8'h11, 8'h00, 8'h10, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'h7F};
      for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], 1'b0);
      dgram.delete();
      repeat (tracker.rtp_header_bytes) dgram.push_back(ts_ape_pkg::BYTE_W'($urandom));
      send_dgram();
      run_phase(PHASE_BYTES, 1);

      wait_drained();
      configure(0, 0, 0);
      run_phase(PHASE_BYTES, 2);

      wait_drained();
      configure(8191, 255, 183);
      run_phase(1, 1);

      // Long response hold-off while requests keep coming without gaps.
      wait_drained();
      configure($urandom_range(0, 8191), $urandom_range(0, 16), $urandom_range(0, 183));
      gaps_on = 1'b0;
      long_hold_go <= 1'b1;
      send_datagram(1'b1, 2);

      wait_drained();
      configure($urandom_range(0, 8191), 1, 183);
      run_phase(PHASE_BYTES, 1);

      wait_drained();
      configure($urandom_range(0, 8191), $urandom_range(0, 20), $urandom_range(0, 183));
      quiet_tail = 1'b1;
      run_phase(PHASE_BYTES, 1);

      wait_drained();
      if (tracker.mismatch_count == 0 && tracker.pending_samples.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+sv
sv/ts_ape_pkg.sv
sv/ts_ape_if.sv
sv/ts_ape_front.sv
sv/ts_ape_queue.sv
sv/ts_ape_back.sv
sv/ts_audio_pid_payload_extractor.sv
tb/sv/tb_ts_audio_pid_payload_extractor.sv
